// ----- hw/rtl/packet_id_gap_reporter_top_defines.svh -----
// Assertion macros for the packet ID gap reporter checker.
// Included by the checker file only; no other dependencies.
`ifndef PACKET_ID_GAP_REPORTER_TOP_DEFINES_SVH
`define PACKET_ID_GAP_REPORTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgr assertion failed");

`endif

// ----- hw/rtl/pgr_pkg.sv -----
// Shared constants and types for the packet ID gap reporter.
// No dependencies; used by every module of the block.
package pgr_pkg;

    localparam int NUM_IDS     = 128;
    localparam int ID_W        = $clog2(NUM_IDS);
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_CONTROL = 1'd1;

    localparam logic [BYTE_W-1:0] TYPE_MASK_RST = 8'h80;

    // Input commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] packet_count;
        logic [ID_W-1:0]    largest_id;
        logic [BYTE_W-1:0]  largest_payload;
    } t_summary;

endpackage

// ----- hw/rtl/pgr_gather.sv -----
// Packet parser plus gathered state: seen-ID store, packet count, largest ID/payload.
// Depends on pgr_pkg. Clear pulse from the report sequencer resets the counters and
// starts a clearing pass over the seen-ID store.
module pgr_gather (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_byte_vld,
    input  logic [pgr_pkg::BYTE_W-1:0]  i_byte,
    input  logic [pgr_pkg::BYTE_W-1:0]  i_type_mask,
    input  logic                        i_track_control,
    input  logic                        i_clear,
    input  logic [pgr_pkg::ID_W-1:0]    i_rd_idx,
    output logic                        o_rd_seen,
    output logic                        o_busy,
    output pgr_pkg::t_summary           o_sum
);
    import pgr_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ID,
        PH_SKIP
    } t_phase;

    t_phase              r_phase;
    logic [BYTE_W-1:0]   r_skip_left;
    logic                r_kind;
    logic [BYTE_W-1:0]   r_payload;
    logic [COUNT_W-1:0]  r_count;
    logic [ID_W-1:0]     r_largest_id;
    logic [BYTE_W-1:0]   r_largest_payload;

    logic                r_seen_mem [NUM_IDS];
    logic                r_rd_seen;
    logic                r_clr_busy;
    logic [ID_W-1:0]     r_clr_idx;

    logic                hdr_ctrl;
    logic                tracked;
    logic                id_in_range;
    logic [ID_W-1:0]     id_val;
    logic                seen_we;

    assign hdr_ctrl    = |(i_byte & i_type_mask);
    assign tracked     = (r_kind == i_track_control);
    assign id_in_range = ({1'b0, i_byte} < (BYTE_W+1)'(NUM_IDS));
    assign id_val      = i_byte[ID_W-1:0];
    assign seen_we     = i_byte_vld && (r_phase == PH_ID) && tracked && id_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase           <= PH_HEADER;
            r_skip_left       <= '0;
            r_kind            <= 1'b0;
            r_payload         <= '0;
            r_count           <= '0;
            r_largest_id      <= '0;
            r_largest_payload <= '0;
        end else if (i_byte_vld) begin
            unique case (r_phase)
                PH_HEADER: begin
                    r_kind <= hdr_ctrl;
                    if (!hdr_ctrl) begin
                        r_payload <= i_byte;
                    end
                    r_phase <= PH_ID;
                end
                PH_ID: begin
                    if (tracked) begin
                        if (r_count != '1) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (id_in_range) begin
                            if (id_val > r_largest_id) begin
                                r_largest_id <= id_val;
                            end
                        end
                        if (!r_kind && (r_payload > r_largest_payload)) begin
                            r_largest_payload <= r_payload;
                        end
                    end
                    if (!r_kind && (r_payload != '0)) begin
                        r_skip_left <= r_payload;
                        r_phase     <= PH_SKIP;
                    end else begin
                        r_phase <= PH_HEADER;
                    end
                end
                PH_SKIP: begin
                    if (r_skip_left > 8'd1) begin
                        r_skip_left <= r_skip_left - 1'b1;
                    end else begin
                        r_skip_left <= '0;
                        r_phase     <= PH_HEADER;
                    end
                end
                default: begin
                    r_phase <= PH_HEADER;
                end
            endcase
        end
    end

    // clearing pass: one entry per cycle over all NUM_IDS entries, after reset and after each report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == ID_W'(NUM_IDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_seen_mem[r_clr_idx] <= 1'b0;
        end else if (seen_we) begin
            r_seen_mem[id_val] <= 1'b1;
        end
        r_rd_seen <= r_seen_mem[i_rd_idx];
    end

    assign o_rd_seen             = r_rd_seen;
    assign o_busy                = r_clr_busy;
    assign o_sum.packet_count    = r_count;
    assign o_sum.largest_id      = r_largest_id;
    assign o_sum.largest_payload = r_largest_payload;

endmodule

// ----- hw/rtl/packet_id_gap_reporter_top.sv -----
// Packet ID gap reporter: top level with config registers, report sequencer
// and result register. Depends on pgr_pkg and pgr_gather.
//
// Usage:
//   Input channel (i_valid / o_stall, fields i_cmd, i_stream_byte): cmd 0 feeds one
//   stream byte, cmd 1 ends the stream and starts a report. Bytes are taken one per
//   cycle while o_stall is low and produce no result.
//   Output channel (o_valid / i_stall): one result per missing-ID run below the
//   largest ID, each carrying the packet count, largest ID and largest payload;
//   o_last_of_report marks the final one. With no runs a single result with
//   o_has_range low is sent. At most 64 results per report.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 type_mask,
//   index 1 track_control. Write only while idle.
// Timing: the walk tests one seen flag per cycle while the output slot is free, from
//   index 0 up to largest_id at most, and then sends the final result; the first result
//   is registered from S_SCAN or S_FINAL after the end-of-stream transfer. A stalled
//   result holds in the output register and freezes the walk. The seen-ID store is
//   then cleared one entry per cycle, all 128 entries; o_stall stays high throughout.
// Reset (synchronous, active low) sets type_mask 0x80, track_control 0, clears
//   parser and counters and starts the same clearing pass over all 128 entries.
module packet_id_gap_reporter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [pgr_pkg::BYTE_W-1:0]     i_stream_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [pgr_pkg::COUNT_W-1:0]    o_packet_count,
    output logic [pgr_pkg::ID_W-1:0]       o_largest_id,
    output logic [pgr_pkg::BYTE_W-1:0]     o_largest_payload,
    output logic                           o_has_range,
    output logic [pgr_pkg::ID_W-1:0]       o_range_start,
    output logic [pgr_pkg::ID_W-1:0]       o_range_end,
    output logic                           o_last_of_report,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pgr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pgr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pgr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL
    } t_state;

    t_state               r_state;
    logic [BYTE_W-1:0]    r_type_mask;
    logic                 r_track_control;

    logic [ID_W-1:0]      r_idx;
    logic                 r_in_run;
    logic [ID_W-1:0]      r_run_start;
    logic                 r_have_buf;
    logic [ID_W-1:0]      r_buf_start;
    logic [ID_W-1:0]      r_buf_end;
    logic [RES_CNT_W-1:0] r_nres;

    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;
    logic [ID_W-1:0]      r_out_largest_id;
    logic [BYTE_W-1:0]    r_out_largest_payload;
    logic                 r_out_has;
    logic [ID_W-1:0]      r_out_start;
    logic [ID_W-1:0]      r_out_end;
    logic                 r_out_last;

    t_summary             sum;
    logic                 rd_seen;
    logic                 clr_busy;
    logic                 in_acc;
    logic                 byte_vld;
    logic                 slot_free;
    logic                 clear;
    logic                 at_end;
    logic                 run_done;
    logic                 run_new;
    logic                 cap_hit;
    logic                 scan_adv;
    logic                 out_load;
    logic [ID_W-1:0]      rd_idx;
    logic [ID_W-1:0]      run_end;
    logic [BYTE_W-1:0]    sum_payload;

    pgr_gather u_gather (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_vld      (byte_vld),
        .i_byte          (i_stream_byte),
        .i_type_mask     (r_type_mask),
        .i_track_control (r_track_control),
        .i_clear         (clear),
        .i_rd_idx        (rd_idx),
        .o_rd_seen       (rd_seen),
        .o_busy          (clr_busy),
        .o_sum           (sum)
    );

    assign o_stall     = (r_state != S_IDLE) || clr_busy;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign byte_vld    = in_acc && (i_cmd == CMD_BYTE);
    assign slot_free   = !r_out_valid || !i_stall;
    assign clear       = (r_state == S_FINAL) && slot_free;

    // one step of the walk: compare index against the top, test its flag
    assign at_end   = (r_idx == sum.largest_id);
    assign run_done = r_in_run && (at_end || rd_seen);
    assign run_new  = !r_in_run && !at_end && !rd_seen;
    assign run_end  = r_idx - 1'b1;
    assign cap_hit  = run_done && (r_nres == RES_CNT_W'(MAX_RESULTS - 1));
    assign sum_payload = r_track_control ? '0 : sum.largest_payload;

    // store read is registered, so the address runs one step ahead of r_idx
    assign scan_adv = (r_state == S_SCAN) && slot_free && !at_end && !cap_hit;
    assign rd_idx   = (r_state == S_IDLE) ? '0 : (scan_adv ? r_idx + 1'b1 : r_idx);
    assign out_load = slot_free && (((r_state == S_SCAN) && run_done && r_have_buf)
                                    || (r_state == S_FINAL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_mask     <= TYPE_MASK_RST;
            r_track_control <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TYPE_MASK:     r_type_mask     <= i_cfg_data;
                REG_TRACK_CONTROL: r_track_control <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_in_run    <= 1'b0;
            r_have_buf  <= 1'b0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_cmd == CMD_EOS)) begin
                        r_idx      <= '0;
                        r_in_run   <= 1'b0;
                        r_have_buf <= 1'b0;
                        r_nres     <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (slot_free) begin
                        if (run_done) begin
                            // one run held back so the final one can carry the last flag
                            if (r_have_buf) begin
                                r_out_count           <= sum.packet_count;
                                r_out_largest_id      <= sum.largest_id;
                                r_out_largest_payload <= sum_payload;
                                r_out_has             <= 1'b1;
                                r_out_start           <= r_buf_start;
                                r_out_end             <= r_buf_end;
                                r_out_last            <= 1'b0;
                            end
                            r_buf_start <= r_run_start;
                            r_buf_end   <= run_end;
                            r_have_buf  <= 1'b1;
                            r_nres      <= r_nres + 1'b1;
                            r_in_run    <= 1'b0;
                        end
                        if (run_new) begin
                            r_in_run    <= 1'b1;
                            r_run_start <= r_idx;
                        end
                        if (at_end || cap_hit) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FINAL: begin
                    if (slot_free) begin
                        r_out_count           <= sum.packet_count;
                        r_out_largest_id      <= sum.largest_id;
                        r_out_largest_payload <= sum_payload;
                        r_out_has             <= r_have_buf;
                        r_out_start           <= r_have_buf ? r_buf_start : '0;
                        r_out_end             <= r_have_buf ? r_buf_end : '0;
                        r_out_last            <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_packet_count    = r_out_count;
    assign o_largest_id      = r_out_largest_id;
    assign o_largest_payload = r_out_largest_payload;
    assign o_has_range       = r_out_has;
    assign o_range_start     = r_out_start;
    assign o_range_end       = r_out_end;
    assign o_last_of_report  = r_out_last;

endmodule

// ----- hw/rtl/pgr_checker.sv -----
// Port-level checker for the packet ID gap reporter, bound to the top level.
// Depends on pgr_pkg and the assertion macros in the defines header.
`include "packet_id_gap_reporter_top_defines.svh"

module pgr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_has_range,
    input logic [pgr_pkg::ID_W-1:0]    o_range_start,
    input logic [pgr_pkg::ID_W-1:0]    o_range_end,
    input logic                        o_last_of_report
);
    import pgr_pkg::*;

    // stalled result stays offered with its range fields unchanged
    `PGR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_range_start) && $stable(o_range_end))

    // a non-final result means the walk is still running, so input is held off
    `PGR_ASSERT_IMPLY(a_mid_report_stall, i_clk, i_rst_n, o_valid && !o_last_of_report, o_stall)

    // the "no runs" result is always the only, final one and carries zeros
    `PGR_ASSERT_IMPLY(a_empty_last, i_clk, i_rst_n, o_valid && !o_has_range, o_last_of_report && (o_range_start == '0) && (o_range_end == '0))

    // a reported run is never reversed
    `PGR_ASSERT_IMPLY(a_run_order, i_clk, i_rst_n, o_valid && o_has_range, o_range_start <= o_range_end)

endmodule

bind packet_id_gap_reporter_top pgr_checker u_pgr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_has_range      (o_has_range),
    .o_range_start    (o_range_start),
    .o_range_end      (o_range_end),
    .o_last_of_report (o_last_of_report)
);
